>>> sv/pmqes_pkg.sv
// pmqes_pkg: item types, result codes and register map of the event server
// used by every module of the priority multi-queue event server
// no dependencies
package pmqes_pkg;

	// command codes of an input item
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_SERVE  = 1'b1;

	// result kind codes
	localparam logic [1:0] KIND_QUEUED  = 2'd0;
	localparam logic [1:0] KIND_DROPPED = 2'd1;
	localparam logic [1:0] KIND_SERVED  = 2'd2;
	localparam logic [1:0] KIND_IDLE    = 2'd3;

	// register index of the device count register
	localparam logic REG_DEVICES_IN_USE = 1'b0;
	localparam logic [3:0] DEVICES_RESET = 4'd8;

	// field widths
	localparam int ID_W     = 16;
	localparam int TIME_W   = 32;
	localparam int TOTAL_W  = 48;
	localparam int COUNT_W  = 32;
	localparam int ENTRY_W  = ID_W + TIME_W;

	// input item
	typedef struct packed {
		logic              cmd;
		logic [2:0]        device;
		logic [ID_W-1:0]   event_id;
		logic [TIME_W-1:0] event_time;
		logic [TIME_W-1:0] now;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         out_device;
		logic [ID_W-1:0]    out_event_id;
		logic [TIME_W-1:0]  elapsed;
		logic [TOTAL_W-1:0] time_total;
		logic [COUNT_W-1:0] time_count;
	} out_item_t;

	// queue stage outcome, handed to the elapsed stage
	typedef struct packed {
		logic [1:0]        kind;
		logic              acc_en;
		logic [2:0]        device;
		logic [ID_W-1:0]   event_id;
		logic [TIME_W-1:0] event_time;
		logic [TIME_W-1:0] now;
	} q_res_t;

	// accumulate stage input
	typedef struct packed {
		logic [1:0]        kind;
		logic              acc_en;
		logic [2:0]        device;
		logic [ID_W-1:0]   event_id;
		logic [TIME_W-1:0] elapsed;
	} acc_in_t;

endpackage

>>> sv/pmqes_queue.sv
// pmqes_queue: per-device fifo pointers, priority scan and event store
// holds stage 1 decision logic and the registered store read of stage 2
// depends on pmqes_pkg
module pmqes_queue #(
	parameter int NUM_DEVICES = 8,
	parameter int QUEUE_DEPTH = 8,
	localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pmqes_pkg::in_item_t req_s1,
	input  logic                adv_s2,
	input  logic [3:0]          dev_cnt,
	output pmqes_pkg::q_res_t   res_s2,
	output logic [DW-1:0]       idx_s2
);
	import pmqes_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = NUM_DEVICES * QUEUE_DEPTH;
	localparam int AW = (MD > 1) ? $clog2(MD) : 1;

	logic [CW-1:0]      fill_q [NUM_DEVICES];
	logic [PW-1:0]      head_q [NUM_DEVICES];
	logic [ENTRY_W-1:0] store [MD];
	logic [ENTRY_W-1:0] rd_s2;
	q_res_t             hold_s2;

	logic          is_arr;
	logic [DW-1:0] arr_idx;
	logic          arr_ok;
	logic [CW-1:0] arr_fill;
	logic          arr_full;
	logic [PW:0]   tail_sum;
	logic [PW-1:0] slot;
	logic          found;
	logic [DW-1:0] srv_idx;
	logic [PW-1:0] srv_head;
	logic [PW-1:0] srv_next;
	logic          do_wr;
	logic          do_rd;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	q_res_t        nxt;
	logic [DW-1:0] nxt_idx;

	// arrival side: device check, fullness and tail slot
	always_comb begin
		is_arr   = (req_s1.cmd == CMD_ARRIVE);
		arr_idx  = DW'(req_s1.device);
		arr_ok   = ({1'b0, req_s1.device} < dev_cnt) && (32'(req_s1.device) < NUM_DEVICES);
		arr_fill = fill_q[arr_idx];
		arr_full = (arr_fill == CW'(QUEUE_DEPTH));
		tail_sum = (PW+1)'(head_q[arr_idx]) + (PW+1)'(arr_fill);
		if (tail_sum >= (PW+1)'(QUEUE_DEPTH)) begin
			slot = PW'(tail_sum - (PW+1)'(QUEUE_DEPTH));
		end else begin
			slot = PW'(tail_sum);
		end
	end

	// serve side: lowest enabled non-empty device wins
	always_comb begin
		found   = 1'b0;
		srv_idx = '0;
		for (int d = NUM_DEVICES - 1; d >= 0; d--) begin
			if ((32'(d) < 32'(dev_cnt)) && (fill_q[d] != '0)) begin
				found   = 1'b1;
				srv_idx = DW'(d);
			end
		end
		srv_head = head_q[srv_idx];
		srv_next = (srv_head == PW'(QUEUE_DEPTH - 1)) ? '0 : srv_head + 1'b1;
	end

	// store access
	always_comb begin
		do_wr = adv_s2 && is_arr && arr_ok && !arr_full;
		do_rd = adv_s2 && !is_arr && found;
		waddr = AW'(arr_idx) * AW'(QUEUE_DEPTH) + AW'(slot);
		raddr = AW'(srv_idx) * AW'(QUEUE_DEPTH) + AW'(srv_head);
	end

	// outcome of the item for the next stage
	always_comb begin
		nxt.now = req_s1.now;
		if (is_arr) begin
			nxt.kind       = (arr_ok && !arr_full) ? KIND_QUEUED : KIND_DROPPED;
			nxt.acc_en     = arr_ok;
			nxt.device     = req_s1.device;
			nxt.event_id   = req_s1.event_id;
			nxt.event_time = req_s1.event_time;
			nxt_idx        = arr_idx;
		end else begin
			nxt.kind       = found ? KIND_SERVED : KIND_IDLE;
			nxt.acc_en     = found;
			nxt.device     = found ? 3'(srv_idx) : 3'd0;
			nxt.event_id   = '0;
			nxt.event_time = req_s1.now;
			nxt_idx        = srv_idx;
		end
	end

	// fifo pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DEVICES; d++) begin
				fill_q[d] <= '0;
				head_q[d] <= '0;
			end
		end else begin
			if (do_wr) begin
				fill_q[arr_idx] <= arr_fill + 1'b1;
			end
			if (do_rd) begin
				fill_q[srv_idx] <= fill_q[srv_idx] - 1'b1;
				head_q[srv_idx] <= srv_next;
			end
		end
	end

	// event store, registered read
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store[waddr] <= {req_s1.event_id, req_s1.event_time};
		end
		if (do_rd) begin
			rd_s2 <= store[raddr];
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			hold_s2 <= nxt;
			idx_s2  <= nxt_idx;
		end
	end

	// a served item takes id and time from the store
	always_comb begin
		res_s2 = hold_s2;
		if (hold_s2.kind == KIND_SERVED) begin
			res_s2.event_id   = rd_s2[ENTRY_W-1:TIME_W];
			res_s2.event_time = rd_s2[TIME_W-1:0];
		end
	end

endmodule

>>> sv/pmqes_accum.sv
// pmqes_accum: saturating per-device time sums and tallies, result register
// last pipeline stage of the event server
// depends on pmqes_pkg
module pmqes_accum #(
	parameter int NUM_DEVICES = 8,
	localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  pmqes_pkg::acc_in_t   acc_s3,
	input  logic [DW-1:0]        idx_s3,
	output pmqes_pkg::out_item_t rsp_q
);
	import pmqes_pkg::*;

	logic [TOTAL_W-1:0] rsum_q [NUM_DEVICES];
	logic [COUNT_W-1:0] rtal_q [NUM_DEVICES];
	logic [TOTAL_W-1:0] tsum_q [NUM_DEVICES];
	logic [COUNT_W-1:0] ttal_q [NUM_DEVICES];

	logic               served;
	logic [TOTAL_W-1:0] base_sum;
	logic [COUNT_W-1:0] base_tal;
	logic [TOTAL_W:0]   add;
	logic [TOTAL_W-1:0] new_sum;
	logic [COUNT_W-1:0] new_tal;

	// saturating update of the selected sum and tally
	always_comb begin
		served   = (acc_s3.kind == KIND_SERVED);
		base_sum = served ? tsum_q[idx_s3] : rsum_q[idx_s3];
		base_tal = served ? ttal_q[idx_s3] : rtal_q[idx_s3];
		add      = {1'b0, base_sum} + (TOTAL_W+1)'(acc_s3.elapsed);
		new_sum  = add[TOTAL_W] ? '1 : add[TOTAL_W-1:0];
		new_tal  = (base_tal == '1) ? base_tal : base_tal + 1'b1;
	end

	// per-device statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DEVICES; d++) begin
				rsum_q[d] <= '0;
				rtal_q[d] <= '0;
				tsum_q[d] <= '0;
				ttal_q[d] <= '0;
			end
		end else if (load && acc_s3.acc_en) begin
			if (served) begin
				tsum_q[idx_s3] <= new_sum;
				ttal_q[idx_s3] <= new_tal;
			end else begin
				rsum_q[idx_s3] <= new_sum;
				rtal_q[idx_s3] <= new_tal;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.kind         <= acc_s3.kind;
			rsp_q.out_device   <= acc_s3.device;
			rsp_q.out_event_id <= acc_s3.event_id;
			rsp_q.elapsed      <= acc_s3.elapsed;
			rsp_q.time_total   <= acc_s3.acc_en ? new_sum : '0;
			rsp_q.time_count   <= acc_s3.acc_en ? new_tal : '0;
		end
	end

endmodule

>>> sv/priority_multi_queue_event_server_unit.sv
// priority_multi_queue_event_server_unit: strict-priority multi-fifo event server
// top level: config register, pipeline control and elapsed-time stage
// depends on pmqes_pkg, pmqes_queue, pmqes_accum
//
// Usage: req carries one item (arrival of an event on a device, or a serve
// request); rsp carries exactly one result per item, in order. Both channels
// use valid/ready. An arrival is queued on its device's fifo or dropped when
// that fifo is full or the device is not enabled; a serve pops the head of the
// lowest-numbered enabled non-empty device, or reports idle.
// The apb port holds devices_in_use at byte address 0 (reset value 8); write
// it only while no item is in flight.
// Timing: four register stages (input, queue/store read, elapsed, result).
// A result passes the input, queue, elapsed and result registers in turn. One item
// per cycle is taken in steady state while rsp_ready stays high; the queue pointers
// are updated in stage 1 and the statistics in the last stage.
// Reset clears all fifos and statistics; the event store needs no clearing.
// When rsp_ready is low, stages fill up behind the result register and
// req_ready drops only once every stage holds an item.
module priority_multi_queue_event_server_unit #(
	parameter int NUM_DEVICES = 8,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pmqes_pkg::in_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output pmqes_pkg::out_item_t rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import pmqes_pkg::*;

	localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

	logic [3:0]    devs_q;
	logic          v_s1;
	logic          v_s2;
	logic          v_s3;
	logic          out_valid_q;
	in_item_t      req_s1;
	q_res_t        res_s2;
	logic [DW-1:0] idx_s2;
	acc_in_t       acc_s3;
	logic [DW-1:0] idx_s3;
	logic          ld_out;
	logic          ld_s3;
	logic          ld_s2;
	logic          ld_s1;

	// config register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			devs_q <= DEVICES_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DEVICES_IN_USE)) begin
			devs_q <= pwdata[3:0];
		end
	end
	assign prdata = (paddr[2] == REG_DEVICES_IN_USE) ? {28'd0, devs_q} : 32'd0;

	// stage advance chain
	always_comb begin
		ld_out    = v_s3 && (!out_valid_q || rsp_ready);
		ld_s3     = v_s2 && (!v_s3 || ld_out);
		ld_s2     = v_s1 && (!v_s2 || ld_s3);
		req_ready = !v_s1 || ld_s2;
		ld_s1     = req_valid && req_ready;
	end
	assign rsp_valid = out_valid_q;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= 1'b1;
			end else if (ld_s2) begin
				v_s1 <= 1'b0;
			end
			if (ld_s2) begin
				v_s2 <= 1'b1;
			end else if (ld_s3) begin
				v_s2 <= 1'b0;
			end
			if (ld_s3) begin
				v_s3 <= 1'b1;
			end else if (ld_out) begin
				v_s3 <= 1'b0;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			req_s1 <= req;
		end
	end

	pmqes_queue #(
		.NUM_DEVICES(NUM_DEVICES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req_s1 (req_s1),
		.adv_s2 (ld_s2),
		.dev_cnt(devs_q),
		.res_s2 (res_s2),
		.idx_s2 (idx_s2)
	);

	// elapsed time, modulo 2^32
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			acc_s3.kind     <= res_s2.kind;
			acc_s3.acc_en   <= res_s2.acc_en;
			acc_s3.device   <= res_s2.device;
			acc_s3.event_id <= res_s2.event_id;
			acc_s3.elapsed  <= res_s2.now - res_s2.event_time;
			idx_s3          <= idx_s2;
		end
	end

	pmqes_accum #(
		.NUM_DEVICES(NUM_DEVICES)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (ld_out),
		.acc_s3(acc_s3),
		.idx_s3(idx_s3),
		.rsp_q (rsp)
	);

endmodule
